### rtl/wsp_pkg.sv
// Shared types, widths and constants of the windowed sinc pulse sampler.
// No dependencies; every other file imports this package.
package wsp_pkg;

  // Field and register widths
  localparam int unsigned T_W    = 32;
  localparam int unsigned BW_W   = 24;
  localparam int unsigned ZC_W   = 6;
  localparam int unsigned AP_W   = 17;
  localparam int unsigned PK_W   = 32;
  localparam int unsigned MAG_W  = 32;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CFG_IW = 2;

  // Datapath widths
  localparam int unsigned P_W   = T_W + BW_W;  // sample_time * bandwidth
  localparam int unsigned DX_W  = P_W;         // |x| in Q.32
  localparam int unsigned CW    = 34;          // CORDIC x, y, z
  localparam int unsigned WIN_W = 34;          // window, Q2.30 with headroom
  localparam int unsigned SNC_W = 32;          // sinc, signed Q2.30
  localparam int unsigned WS_W  = 34;          // window * sinc
  localparam int unsigned RES_W = 36;          // scaled magnitude before clamp

  // Divider chains
  localparam int unsigned ZDIV_STEP  = 4;
  localparam int unsigned ZDIV_CELLS = P_W / ZDIV_STEP;
  localparam int unsigned SDIV_CELLS = 32;

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_BANDWIDTH = 2'd0,
    REG_ZERO_CROSS = 2'd1,
    REG_APODIZATION = 2'd2,
    REG_PEAK_AMP = 2'd3
  } reg_idx_e;

  // Constants
  localparam logic [BW_W-1:0]       BW_RESET    = 24'd655360;
  localparam logic [ZC_W-1:0]       ZC_RESET    = 6'd3;
  localparam logic [AP_W-1:0]       AP_RESET    = 17'd32768;
  localparam logic [PK_W-1:0]       PK_RESET    = 32'd16777216;
  localparam logic [AP_W-1:0]       ALPHA_ONE   = 17'd65536;
  localparam logic signed [CW-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0]           INV_PI_Q32  = 32'd1367130551;
  localparam logic signed [SNC_W-1:0] SINC_ONE  = 32'sd1073741824;
  localparam logic [31:0]           SINC_ONE_U  = 32'd1073741824;
  localparam logic [RES_W-1:0]      RES_POS_MAX = 36'h07FFFFFFF;
  localparam logic [RES_W-1:0]      RES_NEG_MAX = 36'h080000000;

  // Arctangent of 2^-i in Q0.32 turns
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Side data carried next to the cell chains
  typedef struct packed {
    logic [31:0]     ph_s;
    logic            xneg;
    logic            zero;
    logic [DX_W-1:0] dx;
  } zside_t;

  typedef struct packed {
    logic            flip_s;
    logic            flip_c;
    logic            xneg;
    logic            zero;
    logic [DX_W-1:0] dx;
  } cside_t;

  typedef struct packed {
    logic [31:0]            sm;
    logic                   sn_neg;
    logic signed [CW-1:0]   cs;
    logic                   xneg;
    logic                   zero;
    logic [DX_W-1:0]        dx;
  } astage_t;

  typedef struct packed {
    logic signed [WIN_W-1:0] win;
    logic                    sgn;
    logic                    zero;
    logic                    sat;
  } sside_t;

  typedef struct packed {
    logic [31:0] r;
    sside_t      sd;
  } bstage_t;

  typedef struct packed {
    logic signed [SNC_W-1:0] sinc;
    logic signed [WIN_W-1:0] win;
  } cstage_t;

  typedef struct packed {
    logic [WS_W-1:0] mag;
    logic            neg;
  } estage_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             neg;
  } fstage_t;

endpackage

### rtl/wsp_sample_if.sv
// Input channel: one time sample per item, valid/ready handshake.
// Depends on wsp_pkg for the field width.
interface wsp_sample_if import wsp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [T_W-1:0] sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink   (input valid, input sample_time, output ready);
endinterface

### rtl/wsp_result_if.sv
// Output channel: one pulse amplitude per item, valid/ready handshake.
// Depends on wsp_pkg for the field width.
interface wsp_result_if import wsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MAG_W-1:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink   (input valid, input magnitude, output ready);
endinterface

### rtl/wsp_zdiv_cell.sv
// One cell of the time / zero-crossings divider: four quotient bits per cell.
// Depends on wsp_pkg.
module wsp_zdiv_cell import wsp_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [P_W-1:0]  num_i,
  input  logic [P_W-1:0]  quo_i,
  input  logic [ZC_W-1:0] rem_i,
  input  logic [ZC_W-1:0] den_i,
  output logic [P_W-1:0]  num_o,
  output logic [P_W-1:0]  quo_o,
  output logic [ZC_W-1:0] rem_o
);

  logic [ZC_W:0]        r;
  logic [ZDIV_STEP-1:0] bits;

  // Shift in dividend bits, subtract where it fits
  always_comb begin
    r    = {1'b0, rem_i};
    bits = '0;
    for (int s = 0; s < ZDIV_STEP; s++) begin
      r = {r[ZC_W-1:0], num_i[P_W-1-s]};
      if (r >= {1'b0, den_i}) begin
        r = r - {1'b0, den_i};
        bits[ZDIV_STEP-1-s] = 1'b1;
      end
    end
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_i << ZDIV_STEP;
      quo_o <= {quo_i[P_W-ZDIV_STEP-1:0], bits};
      rem_o <= r[ZC_W-1:0];
    end
  end

endmodule

### rtl/wsp_cordic_cell.sv
// One rotation-mode CORDIC iteration with a fixed shift and angle.
// Depends on wsp_pkg for widths and the arctangent table.
module wsp_cordic_cell import wsp_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o
);

  logic signed [CW-1:0] dx, dy, ang;

  // Floor shifts and this iteration's angle
  assign dx  = y_i >>> STAGE;
  assign dy  = x_i >>> STAGE;
  assign ang = signed'(CW'(ATAN_TURNS[STAGE]));

  // Rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[CW-1]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ang;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ang;
      end
    end
  end

endmodule

### rtl/wsp_sdiv_cell.sv
// One cell of the sinc divider: one quotient bit of |sin| * 2^32 / |x|.
// Depends on wsp_pkg.
module wsp_sdiv_cell import wsp_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DX_W-1:0] rem_i,
  input  logic [DX_W-1:0] den_i,
  input  logic [31:0]     quo_i,
  output logic [DX_W-1:0] rem_o,
  output logic [DX_W-1:0] den_o,
  output logic [31:0]     quo_o
);

  logic [DX_W:0] r2, diff;
  logic          ge;

  // Shift in a zero bit and try the subtract
  assign r2   = {rem_i, 1'b0};
  assign ge   = r2 >= {1'b0, den_i};
  assign diff = r2 - {1'b0, den_i};

  // Hand remainder, divisor and quotient to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? diff[DX_W-1:0] : r2[DX_W-1:0];
      den_o <= den_i;
      quo_o <= {quo_i[30:0], ge};
    end
  end

endmodule

### rtl/windowed_sinc_pulse_sample.sv
// Top level of the windowed sinc pulse sampler: config registers and pipeline.
// Depends on wsp_pkg, wsp_sample_if, wsp_result_if and the three cell modules.
//
//   channel   dir  payload                       handshake
//   sample_i  in   sample_time  u32 Q16.16       valid/ready
//   result_o  out  magnitude    s32 Q8.24        valid/ready
//   cfg_*     in   cfg_idx_i, cfg_data_i         cfg_we_i, no back-pressure
//
// One item per clock while the chain is not halted. The pipeline is one multiply, 14
// divider cells, the CORDIC cells, 32 sinc divider cells and six stages.
// The whole chain advances together; it halts only while its last stage holds
// an item and the output register still holds one that is not taken.
// Reset clears the valid chain and the output valid flag and loads the config registers with their reset values.
module windowed_sinc_pulse_sample import wsp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_idx_i,
  input  logic [CFG_DW-1:0]  cfg_data_i,
  wsp_sample_if.sink         sample_i,
  wsp_result_if.source       result_o
);

  localparam int unsigned NS    = CORDIC_STAGES;
  localparam int unsigned ST_CO = 1 + ZDIV_CELLS;
  localparam int unsigned ST_A  = ST_CO + NS;
  localparam int unsigned ST_B  = ST_A + 1 + SDIV_CELLS;
  localparam int unsigned ST_C  = ST_B + 1;
  localparam int unsigned ST_F  = ST_C + 3;
  localparam int unsigned LAT   = ST_F + 1;

  // Configuration registers
  logic [BW_W-1:0] bw_q;
  logic [ZC_W-1:0] zc_q;
  logic [AP_W-1:0] ap_q;
  logic [PK_W-1:0] pk_q;
  logic [ZC_W-1:0] zc_eff;
  logic [AP_W-1:0] alpha, alpha_inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= BW_RESET;
      zc_q <= ZC_RESET;
      ap_q <= AP_RESET;
      pk_q <= PK_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_BANDWIDTH:   bw_q <= cfg_data_i[BW_W-1:0];
        REG_ZERO_CROSS:  zc_q <= cfg_data_i[ZC_W-1:0];
        REG_APODIZATION: ap_q <= cfg_data_i[AP_W-1:0];
        REG_PEAK_AMP:    pk_q <= cfg_data_i[PK_W-1:0];
        default: ;
      endcase
    end
  end

  assign zc_eff    = (zc_q == '0) ? ZC_W'(1) : zc_q;
  assign alpha     = (ap_q > ALPHA_ONE) ? ALPHA_ONE : ap_q;
  assign alpha_inv = ALPHA_ONE - alpha;

  // Flow control: valid chain and output register
  logic [LAT-1:0]          vld_q;
  logic                    adv;
  logic                    out_valid_q;
  logic signed [MAG_W-1:0] out_mag_q;

  assign adv              = !(vld_q[LAT-1] && out_valid_q && !result_o.ready);
  assign sample_i.ready   = adv;
  assign result_o.valid   = out_valid_q;
  assign result_o.magnitude = out_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[LAT-2:0], sample_i.valid};
      end
      if (adv && vld_q[LAT-1]) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Multiply time by bandwidth
  logic [P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q <= P_W'(sample_i.sample_time) * P_W'(bw_q);
    end
  end

  // Centre the time and enter the divider chain
  logic [P_W-1:0] zs_val, p_minus, z_minus;
  zside_t         zd_entry;

  assign zs_val  = P_W'(zc_eff) << 32;
  assign p_minus = p_q - zs_val;
  assign z_minus = zs_val - p_q;

  always_comb begin
    zd_entry.xneg = p_q < zs_val;
    zd_entry.zero = p_q == zs_val;
    zd_entry.dx   = zd_entry.xneg ? z_minus : p_minus;
    zd_entry.ph_s = p_minus[32:1];
  end

  logic [P_W-1:0]  zd_num [ZDIV_CELLS+1];
  logic [P_W-1:0]  zd_quo [ZDIV_CELLS+1];
  logic [ZC_W-1:0] zd_rem [ZDIV_CELLS+1];
  zside_t          zd_side_q [ZDIV_CELLS];

  assign zd_num[0] = p_q;
  assign zd_quo[0] = '0;
  assign zd_rem[0] = '0;

  for (genvar k = 0; k < ZDIV_CELLS; k++) begin : g_zdiv
    wsp_zdiv_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (zd_num[k]),
      .quo_i (zd_quo[k]),
      .rem_i (zd_rem[k]),
      .den_i (zc_eff),
      .num_o (zd_num[k+1]),
      .quo_o (zd_quo[k+1]),
      .rem_o (zd_rem[k+1])
    );
  end

  // Delay side data next to the divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zd_side_q[0] <= zd_entry;
      for (int k = 1; k < ZDIV_CELLS; k++) begin
        zd_side_q[k] <= zd_side_q[k-1];
      end
    end
  end

  // Fold phases into the right half plane for the CORDIC
  logic [31:0]          ph_s, ph_c, ph_s2, ph_c2;
  logic                 flip_s, flip_c;
  cside_t               co_entry;

  assign ph_s   = zd_side_q[ZDIV_CELLS-1].ph_s;
  assign ph_c   = {~zd_quo[ZDIV_CELLS][32], zd_quo[ZDIV_CELLS][31:1]};
  assign flip_s = ph_s[31] ^ ph_s[30];
  assign flip_c = ph_c[31] ^ ph_c[30];
  assign ph_s2  = {ph_s[31] ^ flip_s, ph_s[30:0]};
  assign ph_c2  = {ph_c[31] ^ flip_c, ph_c[30:0]};

  always_comb begin
    co_entry.flip_s = flip_s;
    co_entry.flip_c = flip_c;
    co_entry.xneg   = zd_side_q[ZDIV_CELLS-1].xneg;
    co_entry.zero   = zd_side_q[ZDIV_CELLS-1].zero;
    co_entry.dx     = zd_side_q[ZDIV_CELLS-1].dx;
  end

  logic signed [CW-1:0] sx [NS+1];
  logic signed [CW-1:0] sy [NS+1];
  logic signed [CW-1:0] sz [NS+1];
  logic signed [CW-1:0] cx [NS+1];
  logic signed [CW-1:0] cy [NS+1];
  logic signed [CW-1:0] cz [NS+1];
  cside_t               co_side_q [NS];

  assign sx[0] = CORDIC_GAIN;
  assign sy[0] = '0;
  assign sz[0] = signed'({{(CW-32){ph_s2[31]}}, ph_s2});
  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = signed'({{(CW-32){ph_c2[31]}}, ph_c2});

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    wsp_cordic_cell #(.STAGE(i)) u_sin (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (sx[i]),
      .y_i   (sy[i]),
      .z_i   (sz[i]),
      .x_o   (sx[i+1]),
      .y_o   (sy[i+1]),
      .z_o   (sz[i+1])
    );
    wsp_cordic_cell #(.STAGE(i)) u_cos (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  // Delay side data next to the CORDIC
  always_ff @(posedge clk_i) begin
    if (adv) begin
      co_side_q[0] <= co_entry;
      for (int i = 1; i < NS; i++) begin
        co_side_q[i] <= co_side_q[i-1];
      end
    end
  end

  // Unfold sine and cosine, take |sin|
  logic signed [CW-1:0] y_fin, x_fin, y_abs;
  astage_t              a_q;
  cside_t               co_last;

  assign co_last = co_side_q[NS-1];
  assign y_fin   = sy[NS];
  assign x_fin   = cx[NS];
  assign y_abs   = y_fin[CW-1] ? -y_fin : y_fin;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q.sm     <= y_abs[31:0];
      a_q.sn_neg <= (y_fin != '0) && (y_fin[CW-1] ^ co_last.flip_s);
      a_q.cs     <= co_last.flip_c ? -x_fin : x_fin;
      a_q.xneg   <= co_last.xneg;
      a_q.zero   <= co_last.zero;
      a_q.dx     <= co_last.dx;
    end
  end

  // Window value and sinc divider entry
  logic signed [51:0] w_base, w_prod, w_sum;
  sside_t             sd_entry;

  assign w_base = signed'({5'd0, alpha_inv, 30'd0});
  assign w_prod = 52'(signed'({1'b0, alpha})) * 52'(a_q.cs);
  assign w_sum  = w_base + w_prod;

  always_comb begin
    sd_entry.win  = w_sum[WIN_W+15:16];
    sd_entry.sgn  = a_q.sn_neg ^ a_q.xneg;
    sd_entry.zero = a_q.zero;
    sd_entry.sat  = DX_W'(a_q.sm) >= a_q.dx;
  end

  logic [DX_W-1:0] sd_rem [SDIV_CELLS+1];
  logic [DX_W-1:0] sd_den [SDIV_CELLS+1];
  logic [31:0]     sd_quo [SDIV_CELLS+1];
  sside_t          sd_side_q [SDIV_CELLS];

  assign sd_rem[0] = DX_W'(a_q.sm);
  assign sd_den[0] = a_q.dx;
  assign sd_quo[0] = '0;

  for (genvar j = 0; j < SDIV_CELLS; j++) begin : g_sdiv
    wsp_sdiv_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (sd_rem[j]),
      .den_i (sd_den[j]),
      .quo_i (sd_quo[j]),
      .rem_o (sd_rem[j+1]),
      .den_o (sd_den[j+1]),
      .quo_o (sd_quo[j+1])
    );
  end

  // Delay side data next to the sinc divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_side_q[0] <= sd_entry;
      for (int j = 1; j < SDIV_CELLS; j++) begin
        sd_side_q[j] <= sd_side_q[j-1];
      end
    end
  end

  // Scale quotient by 1/pi, pick sinc, multiply by window, scale by peak
  logic [63:0]               r_full;
  logic [31:0]               r_mag;
  logic signed [65:0]        ws_full;
  logic [WS_W+PK_W-1:0]      res_full;
  logic [RES_W-1:0]          res_clamp;
  bstage_t                   b_q;
  cstage_t                   c_q;
  logic signed [WS_W-1:0]    d_q;
  estage_t                   e_q;
  fstage_t                   f_q;

  assign r_full   = 64'(sd_quo[SDIV_CELLS]) * 64'(INV_PI_Q32) + (64'd1 << 31);
  assign r_mag    = (b_q.sd.zero || b_q.sd.sat || b_q.r > SINC_ONE_U) ? SINC_ONE_U : b_q.r;
  assign ws_full  = 66'(c_q.win) * 66'(c_q.sinc);
  assign res_full = (WS_W+PK_W)'(pk_q) * (WS_W+PK_W)'(e_q.mag);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q.r    <= r_full[63:32];
      b_q.sd   <= sd_side_q[SDIV_CELLS-1];
      c_q.win  <= b_q.sd.win;
      c_q.sinc <= (b_q.sd.sgn && !b_q.sd.zero) ? -signed'(r_mag) : signed'(r_mag);
      d_q      <= ws_full[WS_W+29:30];
      e_q.neg  <= d_q[WS_W-1];
      e_q.mag  <= d_q[WS_W-1] ? WS_W'(-d_q) : WS_W'(d_q);
      f_q.neg  <= e_q.neg;
      f_q.res  <= res_full[RES_W+29:30];
    end
  end

  // Saturate and load the output register
  always_comb begin
    if (f_q.neg) begin
      res_clamp = (f_q.res > RES_NEG_MAX) ? RES_NEG_MAX : f_q.res;
    end else begin
      res_clamp = (f_q.res > RES_POS_MAX) ? RES_POS_MAX : f_q.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[LAT-1]) begin
      out_mag_q <= f_q.neg ? -signed'(res_clamp[MAG_W-1:0]) : signed'(res_clamp[MAG_W-1:0]);
    end
  end

  // Checks
  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && out_valid_q && !result_o.ready) |-> !sample_i.ready)
    else $error("input taken while the pipeline is halted");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");

  a_sinc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_C] |-> (c_q.sinc <= SINC_ONE && c_q.sinc >= -SINC_ONE))
    else $error("sinc out of range");

  a_centre_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_B] && adv && b_q.sd.zero) |=> (c_q.sinc == SINC_ONE))
    else $error("sinc not one at pulse centre");

endmodule

### sim/wsp_tb_if.sv
`timescale 1ns / 100ps
// Testbench copies of nothing: the channel interfaces come from the RTL.
// This file holds only a small package of testbench settings; depends on wsp_pkg.
package wsp_tb_pkg;
  import wsp_pkg::*;
  localparam int unsigned TB_STAGES = 24;
  localparam int unsigned TB_LATENCY = 53 + TB_STAGES;
endpackage

### sim/windowed_sinc_pulse_sample_tb.sv
`timescale 1ns / 100ps
// Testbench of the windowed sinc pulse sampler: random and directed time samples,
// predicted amplitudes checked in order. Depends on wsp_pkg, wsp_tb_pkg and the RTL.
module windowed_sinc_pulse_sample_tb;
  import wsp_pkg::*;
  import wsp_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = REG_BANDWIDTH;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  wsp_sample_if sample_ch ();
  wsp_result_if result_ch ();

  windowed_sinc_pulse_sample #(.CORDIC_STAGES(TB_STAGES)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .sample_i(sample_ch.sink), .result_o(result_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Predictor copy of the registers
  logic [BW_W-1:0] bw_q = BW_RESET;
  logic [ZC_W-1:0] zc_q = ZC_RESET;
  logic [AP_W-1:0] ap_q = AP_RESET;
  logic [PK_W-1:0] pk_q = PK_RESET;

  logic [T_W-1:0] pending_times[$];
  logic [MAG_W-1:0] expected_mags[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0, checked = 0;
  longint cycles = 0;
  bit took = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation-mode CORDIC, returns cos and sin in Q2.30
  function automatic void rotate(input logic [31:0] phase, output longint c,
                                 output longint s);
    logic flip;
    longint x, y, z, dx, dy;
    logic [31:0] ph;
    ph = phase;
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph - 32'h80000000;
    z = longint'(signed'(ph));
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < TB_STAGES && i < 32; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [MAG_W-1:0] pulse_amplitude(logic [T_W-1:0] t);
    logic [63:0] zc, alpha, p, zs, dxa, sm, q, r, mag, res;
    logic [31:0] ph_s, ph_c;
    longint cs, sn, unused, sinc, win, ws;
    logic xneg, neg;
    zc = (zc_q == 0) ? 64'd1 : 64'(zc_q);
    alpha = (ap_q > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(ap_q);
    p = 64'(t) * 64'(bw_q);
    zs = zc << 32;
    ph_s = 32'((p - zs) >> 1);
    ph_c = 32'((p / zc) >> 1) + 32'h80000000;
    rotate(ph_s, unused, sn);
    rotate(ph_c, cs, unused);
    if (p == zs) begin
      sinc = SINC_ONE;
    end else begin
      xneg = p < zs;
      dxa = xneg ? zs - p : p - zs;
      sm = sn < 0 ? 64'(-sn) : 64'(sn);
      q = (sm << 32) / dxa;
      if (q > (64'd1 << 33)) q = 64'd1 << 33;
      r = (q * 64'(INV_PI_Q32) + (64'd1 << 31)) >> 32;
      if (r > 64'(SINC_ONE_U)) r = 64'(SINC_ONE_U);
      sinc = ((sn < 0) != xneg) ? -longint'(r) : longint'(r);
    end
    win = floor_shr(longint'(65536 - alpha) * 64'sd1073741824 + longint'(alpha) * cs, 16);
    ws = floor_shr(win * sinc, 30);
    neg = ws < 0;
    mag = neg ? 64'(-ws) : 64'(ws);
    res = (64'(pk_q) * mag) >> 30;
    if (neg) begin
      if (res > 64'h80000000) res = 64'h80000000;
      return 32'(64'd0 - res);
    end
    if (res > 64'h7FFFFFFF) res = 64'h7FFFFFFF;
    return 32'(res);
  endfunction

  // Record each accepted item at the clock edge and predict its result
  always @(posedge clk_i) begin
    took <= rst_ni && sample_ch.valid && sample_ch.ready;
    if (rst_ni && sample_ch.valid && sample_ch.ready) begin
      expected_mags.push_back(pulse_amplitude(sample_ch.sample_time));
      void'(pending_times.pop_front());
    end
  end

  // Driver: hold an offered item until taken, then offer the next or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
    end else if (sample_ch.valid && !took) begin
      sample_ch.valid <= 1'b1;
    end else if (pending_times.size() == 0 || $urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
    end else begin
      sample_ch.valid <= 1'b1;
      sample_ch.sample_time <= pending_times[0];
    end
  end

  // Receiver: random stalls plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      checked <= checked + 1;
      if (expected_mags.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", result_ch.magnitude);
      end else begin
        if (result_ch.magnitude !== expected_mags[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("magnitude mismatch: expected %h got %h",
                     expected_mags[0], result_ch.magnitude);
        end
        void'(expected_mags.pop_front());
      end
    end
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Write one register at a falling edge, idle only
  task automatic write_reg(reg_idx_e idx, logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BANDWIDTH: bw_q = data[BW_W-1:0];
      REG_ZERO_CROSS: zc_q = data[ZC_W-1:0];
      REG_APODIZATION: ap_q = data[AP_W-1:0];
      default: pk_q = data[PK_W-1:0];
    endcase
  endtask

  task automatic drain();
    while (pending_times.size() != 0 || expected_mags.size() != 0) @(negedge clk_i);
    repeat (TB_LATENCY + 4) @(negedge clk_i);
  endtask

  // Well-formed samples sit within the pulse span, the rest is anywhere
  task automatic add_random(int n);
    logic [63:0] span;
    int zcv;
    zcv = (zc_q == 0) ? 1 : int'(zc_q);
    span = ((64'(2 * zcv) << 32) / 64'(bw_q)) + 2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) pending_times.push_back(32'(64'($urandom) % span));
      else pending_times.push_back($urandom);
    end
  endtask

  task automatic set_config(logic [31:0] bw, logic [31:0] zc, logic [31:0] ap,
                            logic [31:0] pk);
    write_reg(REG_BANDWIDTH, bw);
    write_reg(REG_ZERO_CROSS, zc);
    write_reg(REG_APODIZATION, ap);
    write_reg(REG_PEAK_AMP, pk);
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.sample_time = '0;
    result_ch.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: centre, ends, extremes, alpha above one, zero crossings of zero
    send_idle_pct = 21; recv_idle_pct = 73;
    set_config(32'h10000, 3, 32768, PK_RESET);
    pending_times.push_back(32'h30000);      // centre of pulse
    pending_times.push_back(32'h0);
    pending_times.push_back(32'hFFFFFFFF);
    pending_times.push_back(32'h60000);
    pending_times.push_back(32'h2FFFF);
    pending_times.push_back(32'h30001);
    pending_times.push_back(32'h80000000);
    pending_times.push_back(32'h7FFFFFFF);
    pending_times.push_back(32'h55555555);
    pending_times.push_back(32'hAAAAAAAA);
    drain();
    set_config(32'hFFFFFF, 0, 32'h1FFFF, 32'hFFFFFFFF);
    pending_times.push_back(32'h0);
    pending_times.push_back(32'h100);       // near the centre, with zero treated as one
    pending_times.push_back(32'h101);
    pending_times.push_back(32'hFFFFFFFF);
    pending_times.push_back(32'h00FF);
    drain();
    set_config(1, 32, 0, 0);
    pending_times.push_back(32'hFFFFFFFF);
    pending_times.push_back(32'h0);
    pending_times.push_back(32'h12345678);
    drain();

    // Random phases over several settings
    set_config(BW_RESET, ZC_RESET, AP_RESET, 32'h7FFFFFFF);
    add_random(500);
    drain();
    send_idle_pct = 73; recv_idle_pct = 21;
    set_config(32'h8000, 1, 65536, 32'hFFFFFFFF);
    add_random(500);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_config($urandom_range(1, 32'hFFFFFF), $urandom_range(1, 32), 0, $urandom);
    add_random(300);
    hold_cycles = 400;                        // block fills and stalls its input
    drain();
    set_config($urandom_range(1, 32'hFFFF), $urandom_range(0, 63),
               $urandom_range(0, 32'h1FFFF), $urandom);
    add_random(700);
    drain();

    $display("checked %0d amplitudes over seven register settings, with stalls", checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
